@@ rtl/core/stkv_pkg.sv @@
package stkv_pkg;

    localparam int KEY_BITS = 24;

    // operation codes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISSING = 3'd1;
    localparam logic [2:0] ST_TYPE    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    // cell actions at commit
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_INSERT = 2'd2;
    localparam logic [1:0] ACT_REMOVE = 2'd3;

    typedef struct packed {
        logic [1:0]          operation;
        logic [KEY_BITS-1:0] key;
        logic [6:0]          position;
        logic [1:0]          value_type;
        logic [31:0]         value;
    } req_item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic [1:0]  stored_type;
        logic [6:0]  entry_total;
        logic [2:0]  status;
    } rsp_item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [1:0]          vtype;
        logic [31:0]         value;
    } entry_t;

    typedef struct packed {
        logic [1:0]          act;
        logic [KEY_BITS-1:0] key;
        logic [1:0]          vtype;
        logic [31:0]         value;
    } cell_cmd_t;

endpackage

@@ rtl/core/stkv_cell.sv @@
module stkv_cell
    import stkv_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int IDX         = 0
)
(
    input  logic                               clk,
    input  logic                               capture,
    input  req_item_t                          req,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count,
    input  cell_cmd_t                          cmd,
    input  entry_t                             left,
    input  logic                               left_ins,
    input  entry_t                             right,
    output entry_t                             entry,
    output logic                               ins,
    output logic                               hit
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    entry_t entry_reg;
    entry_t entry_next;
    logic   eq_reg;
    logic   gt_reg;
    logic   hit_reg;
    logic   live;
    logic   eq_now;
    logic   pos_match;

    assign live      = CW'(IDX) < count;
    assign eq_now    = live && (entry_reg.key == req.key);
    assign pos_match = live && (int'(req.position) == IDX + 1);

    // compare flags are taken when an item enters and hold until commit
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            eq_reg  <= eq_now;
            gt_reg  <= live && (entry_reg.key > req.key);
            hit_reg <= (req.operation == OP_READ) ? pos_match : eq_now;
        end
        entry_reg <= entry_next;
    end

    // this cell is at or after the insert slot
    assign ins = gt_reg || (count == CW'(IDX));

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.act)
            ACT_UPDATE:
            begin
                if (hit_reg)
                begin
                    entry_next.vtype = cmd.vtype;
                    entry_next.value = cmd.value;
                end
            end
            ACT_INSERT:
            begin
                if (left_ins)
                begin
                    entry_next = left;
                end
                else if (ins)
                begin
                    entry_next.key   = cmd.key;
                    entry_next.vtype = cmd.vtype;
                    entry_next.value = cmd.value;
                end
            end
            ACT_REMOVE:
            begin
                if (eq_reg || gt_reg)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

@@ rtl/core/sorted_typed_key_value_table_top.sv @@
// Sorted typed key/value table.
// A row of TABLE_DEPTH cells holds the entries in ascending key order; each
// cell compares its own key against the request and hands its entry to a
// neighbor when an insert or remove shifts the row by one place.
// req channel: one item carries operation, key, position, value_type, value.
//   Accepted when req_valid is high and req_stall is low.
// rsp channel: one result item per request (found, read_value, stored_type,
//   entry_total, status), held in an output register until taken.
// Timing: the item's compares run in the cells at the accepting edge; the
//   commit cycle selects the matching cell, shifts or updates the row and
//   loads the result into the output register, which raises rsp_valid. A new
//   item is taken only after the previous one has committed.
// Stall: while rsp is stalled a new item is still taken and compared; its
//   commit waits until the output register is free, and req_stall stays high.
// Reset: clears the entry count and the handshake state; entry contents are
//   not cleared, only entries below the count are ever used.
module sorted_typed_key_value_table_top
    import stkv_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic          busy_reg;
    logic          busy_next;
    req_item_t     item_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    rsp_item_t     rsp_reg;

    logic          accept;
    logic          finish;
    logic          full;
    logic          any_hit;
    entry_t        sel;
    logic [1:0]    act;
    rsp_item_t     result;
    cell_cmd_t     cmd;

    entry_t                 ent_w [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] ins_w;
    logic [TABLE_DEPTH-1:0] hit_w;

    assign req_stall = busy_reg;
    assign accept    = req_valid && !busy_reg;
    // commit when the output register is empty or being drained
    assign finish    = busy_reg && (!rsp_valid_reg || !rsp_stall);
    assign full      = count_reg == CW'(TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    assign cmd.act   = finish ? act : ACT_NONE;
    assign cmd.key   = item_reg.key;
    assign cmd.vtype = item_reg.value_type;
    assign cmd.value = item_reg.value;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t left_ent;
        entry_t right_ent;
        logic   left_ins;

        if (i == 0)
        begin : g_first
            assign left_ent = '0;
            assign left_ins = 1'b0;
        end
        else
        begin : g_mid
            assign left_ent = ent_w[i-1];
            assign left_ins = ins_w[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign right_ent = ent_w[i];
        end
        else
        begin : g_inner
            assign right_ent = ent_w[i+1];
        end

        stkv_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .IDX         (i)
        ) u_cell (
            .clk      (clk),
            .capture  (accept),
            .req      (req),
            .count    (count_reg),
            .cmd      (cmd),
            .left     (left_ent),
            .left_ins (left_ins),
            .right    (right_ent),
            .entry    (ent_w[i]),
            .ins      (ins_w[i]),
            .hit      (hit_w[i])
        );
    end

    // ------------------------------------------------------------------
    // Matching entry select: at most one cell hits
    // ------------------------------------------------------------------
    always_comb
    begin
        sel = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (hit_w[i])
            begin
                sel = sel | ent_w[i];
            end
        end
    end

    assign any_hit = |hit_w;

    // ------------------------------------------------------------------
    // Result and row action
    // ------------------------------------------------------------------
    always_comb
    begin
        result     = '0;
        act        = ACT_NONE;
        count_next = count_reg;
        case (item_reg.operation)
            OP_LOOKUP, OP_READ:
            begin
                if (!any_hit)
                begin
                    result.status = (item_reg.operation == OP_READ) ? ST_RANGE : ST_MISSING;
                end
                else if (sel.vtype != item_reg.value_type)
                begin
                    result.stored_type = sel.vtype;
                    result.status      = ST_TYPE;
                end
                else
                begin
                    result.found       = 1'b1;
                    result.read_value  = sel.value;
                    result.stored_type = sel.vtype;
                end
            end
            OP_SET:
            begin
                if (any_hit || !full)
                begin
                    act                = any_hit ? ACT_UPDATE : ACT_INSERT;
                    count_next         = any_hit ? count_reg : count_reg + 1'b1;
                    result.found       = 1'b1;
                    result.read_value  = item_reg.value;
                    result.stored_type = item_reg.value_type;
                end
                else
                begin
                    result.status = ST_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (any_hit)
                begin
                    act                = ACT_REMOVE;
                    count_next         = count_reg - 1'b1;
                    result.found       = 1'b1;
                    result.read_value  = sel.value;
                    result.stored_type = sel.vtype;
                end
                else
                begin
                    result.status = ST_MISSING;
                end
            end
            default:
            begin
                result.status = ST_MISSING;
            end
        endcase
        result.entry_total = 7'(count_next);
    end

    // ------------------------------------------------------------------
    // Control and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
            if (finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if (finish)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot0(hit_w))
        else $error("more than one cell matched");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> rsp_valid)
        else $error("commit did not load a result");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !finish |=> $stable(count_reg))
        else $error("entry count moved outside a commit");

endmodule

@@ bench/kv_table_checker.sv @@
module kv_table_checker
    import stkv_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_item_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_item_t rsp,
    output int        mismatch_count,
    output int        outstanding
);

    // shadow of the sorted row
    logic [KEY_BITS-1:0] row_key   [TABLE_DEPTH];
    logic [1:0]          row_type  [TABLE_DEPTH];
    logic [31:0]         row_value [TABLE_DEPTH];
    int                  row_count;

    rsp_item_t           answers_due[$];
    rsp_item_t           want;
    int                  rsp_seen;

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] exp_val);
        $display("%0t: item %0d %s mismatch: got %0h, want %0h",
                 $time, rsp_seen, field, got, exp_val);
        mismatch_count++;
    endtask

    // applies one request to the shadow row and returns the answer it earns
    function automatic rsp_item_t table_apply(input req_item_t r);
        rsp_item_t a;
        int        slot;
        bit        hit;
        a    = '0;
        slot = row_count;
        for (int i = 0; i < row_count; i++)
            if (slot == row_count && row_key[i] >= r.key)
                slot = i;
        hit = (slot < row_count) && (row_key[slot] == r.key);

        case (r.operation)
            OP_LOOKUP, OP_READ:
            begin
                if (r.operation == OP_READ)
                begin
                    hit  = (r.position != 0) && (r.position <= row_count);
                    slot = int'(r.position) - 1;
                end
                if (!hit)
                    a.status = (r.operation == OP_READ) ? ST_RANGE : ST_MISSING;
                else if (row_type[slot] != r.value_type)
                begin
                    a.stored_type = row_type[slot];
                    a.status      = ST_TYPE;
                end
                else
                begin
                    a.found       = 1'b1;
                    a.read_value  = row_value[slot];
                    a.stored_type = r.value_type;
                    a.status      = ST_OK;
                end
            end
            OP_SET:
            begin
                if (!hit && row_count >= TABLE_DEPTH)
                    a.status = ST_FULL;
                else
                begin
                    if (!hit)
                    begin
                        for (int i = row_count; i > slot; i--)
                        begin
                            row_key[i]   = row_key[i-1];
                            row_type[i]  = row_type[i-1];
                            row_value[i] = row_value[i-1];
                        end
                        row_count++;
                        row_key[slot] = r.key;
                    end
                    row_type[slot]  = r.value_type;
                    row_value[slot] = r.value;
                    a.found         = 1'b1;
                    a.read_value    = r.value;
                    a.stored_type   = r.value_type;
                    a.status        = ST_OK;
                end
            end
            default:
            begin
                if (!hit)
                    a.status = ST_MISSING;
                else
                begin
                    a.found       = 1'b1;
                    a.read_value  = row_value[slot];
                    a.stored_type = row_type[slot];
                    a.status      = ST_OK;
                    for (int i = slot; i + 1 < row_count; i++)
                    begin
                        row_key[i]   = row_key[i+1];
                        row_type[i]  = row_type[i+1];
                        row_value[i] = row_value[i+1];
                    end
                    row_count--;
                end
            end
        endcase
        a.entry_total = row_count[6:0];
        return a;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mismatch_count = 0;
            row_count      = 0;
            rsp_seen       = 0;
            answers_due.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (answers_due.size() == 0)
                    report("unexpected", 64'(rsp), '0);
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.found !== want.found)
                        report("found", 64'(rsp.found), 64'(want.found));
                    if (rsp.read_value !== want.read_value)
                        report("read_value", 64'(rsp.read_value), 64'(want.read_value));
                    if (rsp.stored_type !== want.stored_type)
                        report("stored_type", 64'(rsp.stored_type), 64'(want.stored_type));
                    if (rsp.entry_total !== want.entry_total)
                        report("entry_total", 64'(rsp.entry_total), 64'(want.entry_total));
                    if (rsp.status !== want.status)
                        report("status", 64'(rsp.status), 64'(want.status));
                end
                rsp_seen++;
            end
            if (req_valid && !req_stall)
                answers_due.push_back(table_apply(req));
        end
        outstanding <= answers_due.size();
    end

endmodule

@@ bench/testbench.sv @@
module testbench
    import stkv_pkg::*;
();

    localparam int DEPTH       = 64;
    localparam int ITEMS       = 1950;
    localparam int POOL        = 96;        // more keys than slots, so the row can fill
    localparam int CYCLE_LIMIT = 1000000;

    // operation mix of one random phase
    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    int        mismatches;
    int        outstanding;
    int        cycles;
    int        sent;
    bit        quiet;       // phase with no sender gaps

    logic [KEY_BITS-1:0] key_pool [POOL];

    sorted_typed_key_value_table_top #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // watches both channels, keeps its own copy of the table, compares answers
    kv_table_checker #(
        .TABLE_DEPTH (DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .mismatch_count (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Receiver back-pressure. Runs of a fixed level: long quiet stretches with no
    // stall, short on/off chatter, and now and then a long stall so that the
    // block has to hold a finished answer while a new item waits behind it.
    initial
    begin
        int run_left;
        bit level;
        int r;
        run_left  = 0;
        level     = 1'b0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (run_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                begin
                    level    = 1'b0;
                    run_left = $urandom_range(20, 80);
                end
                else if (r < 60)
                begin
                    level    = 1'b0;
                    run_left = $urandom_range(1, 4);
                end
                else if (r < 95)
                begin
                    level    = 1'b1;
                    run_left = $urandom_range(1, 3);
                end
                else
                begin
                    level    = 1'b1;
                    run_left = $urandom_range(10, 40);
                end
            end
            run_left--;
            rsp_stall <= level;
        end
    end

    // sender gap after an accepted item: mostly none or short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Presents one item and holds it until taken. valid stays high straight
    // into the next item when there is no gap, so it is never dropped and
    // raised within one step.
    task automatic send_op(input logic [1:0] op, input logic [KEY_BITS-1:0] k,
                           input logic [6:0] pos, input logic [1:0] vt,
                           input logic [31:0] v);
        int gap;
        req       <= '{operation: op, key: k, position: pos, value_type: vt, value: v};
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender holds off until every answer is back; the count the checker
    // reports is registered, hence the first wait
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // One random item. Keys come mostly from a small pool so that lookups,
    // overwrites and removes hit live entries and the row fills up; a few keys
    // are fully random. Type 0 shows up now and then, as do positions past
    // the row and up to the field's top.
    task automatic random_step(input mix_t mix);
        int                  r;
        logic [1:0]          op;
        logic [KEY_BITS-1:0] k;
        logic [1:0]          vt;
        logic [31:0]         v;
        logic [6:0]          pos;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
                op = (r < 65) ? OP_SET : (r < 78) ? OP_LOOKUP : (r < 90) ? OP_READ : OP_REMOVE;
            MIX_SHRINK:
                op = (r < 55) ? OP_REMOVE : (r < 70) ? OP_SET : (r < 85) ? OP_LOOKUP : OP_READ;
            default:
                op = (r < 25) ? OP_SET : (r < 50) ? OP_REMOVE : (r < 75) ? OP_LOOKUP : OP_READ;
        endcase
        if ($urandom_range(0, 9) == 0)
            k = KEY_BITS'($urandom());
        else
            k = key_pool[$urandom_range(0, POOL - 1)];
        if ($urandom_range(0, 19) == 0)
            vt = 2'd0;
        else
            vt = 2'($urandom_range(1, 3));
        r = $urandom_range(0, 9);
        v = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom());
        if ($urandom_range(0, 9) == 0)
            pos = 7'($urandom_range(0, 127));
        else
            pos = 7'($urandom_range(0, DEPTH + 2));
        send_op(op, k, pos, vt, v);
    endtask

    initial
    begin
        int   random_sent;
        int   phase_len;
        mix_t mix;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        quiet       = 1'b0;
        sent        = 0;
        random_sent = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL; i++)
            key_pool[i] = KEY_BITS'($urandom());

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table misses, type 0 round trip, keys at both ends,
        // an insert in the middle, overwrite with a new type, wrong-type hits,
        // position 0 / past the end / field max, removes of first and last.
        send_op(OP_LOOKUP, 24'h000000, 7'd1,   2'd1, 32'h0);
        send_op(OP_READ,   24'h000000, 7'd0,   2'd1, 32'h0);
        send_op(OP_READ,   24'h000000, 7'd1,   2'd1, 32'h0);
        send_op(OP_REMOVE, 24'h000005, 7'd1,   2'd1, 32'h0);
        send_op(OP_SET,    24'h000000, 7'd1,   2'd0, 32'h0);
        send_op(OP_LOOKUP, 24'h000000, 7'd1,   2'd0, 32'h0);
        send_op(OP_LOOKUP, 24'h000000, 7'd1,   2'd2, 32'h0);
        send_op(OP_SET,    24'hFFFFFF, 7'd127, 2'd3, 32'hFFFF_FFFF);
        send_op(OP_SET,    24'h800000, 7'd64,  2'd2, 32'h1234_5678);
        send_op(OP_SET,    24'h000001, 7'd1,   2'd1, 32'h0000_0001);
        send_op(OP_SET,    24'h800000, 7'd1,   2'd1, 32'h0);
        send_op(OP_READ,   24'h000000, 7'd1,   2'd0, 32'h0);
        send_op(OP_READ,   24'h000000, 7'd4,   2'd3, 32'h0);
        send_op(OP_READ,   24'h000000, 7'd5,   2'd3, 32'h0);
        send_op(OP_READ,   24'hFFFFFF, 7'd127, 2'd3, 32'hFFFF_FFFF);
        send_op(OP_READ,   24'h000000, 7'd2,   2'd2, 32'h0);
        send_op(OP_LOOKUP, 24'h800000, 7'd1,   2'd1, 32'h0);
        send_op(OP_REMOVE, 24'h000001, 7'd1,   2'd1, 32'h0);
        send_op(OP_REMOVE, 24'h000001, 7'd1,   2'd1, 32'h0);
        send_op(OP_LOOKUP, 24'h7FFFFF, 7'd1,   2'd2, 32'h0);
        send_op(OP_REMOVE, 24'hFFFFFF, 7'd1,   2'd1, 32'h0);
        send_op(OP_REMOVE, 24'h000000, 7'd1,   2'd1, 32'h0);
        send_op(OP_READ,   24'h000000, 7'd1,   2'd1, 32'h0);

        // full stop before the random part: nothing in flight
        drain();

        // Random phases, each with its own operation mix; grow phases push the
        // row to full, shrink phases drain it to empty. Some phases run with
        // no sender gaps, and some end with a full drain.
        while (random_sent < ITEMS)
        begin
            mix       = mix_t'($urandom_range(0, 2));
            quiet     = ($urandom_range(0, 2) == 0);
            phase_len = $urandom_range(60, 200);
            for (int i = 0; i < phase_len && random_sent < ITEMS; i++)
            begin
                random_step(mix);
                random_sent++;
            end
            if ($urandom_range(0, 3) == 0)
                drain();
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
